>>> src/bgd_pkg.sv
package bgd_pkg;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_TRIT  = 2'd1,
    KIND_QUINT = 2'd2
  } kind_e;

  localparam int unsigned NumVals  = 5;
  localparam int unsigned StreamW  = 38;
  localparam int unsigned ValW     = 8;
  localparam int unsigned DigitW   = 3;
  localparam int unsigned UsedW    = 6;
  localparam int unsigned NW       = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned EncW     = 6;

  localparam logic [IdxW-1:0] LastPlain = 3'd0;
  localparam logic [IdxW-1:0] LastTrit  = 3'd4;
  localparam logic [IdxW-1:0] LastQuint = 3'd2;

  typedef logic [NumVals-1:0][ValW-1:0]   vals_t;
  typedef logic [NumVals-1:0][DigitW-1:0] digits_t;
  typedef logic [255:0][EncW-1:0]         enc_tab_t;

  typedef struct packed {
    kind_e            kind;
    logic [NW-1:0]    n;
    vals_t            m;
    digits_t          d;
    logic [UsedW-1:0] used;
    logic             fin;
  } entry_t;

  // {kind, n} for every range maximum: largest form 2^n-1, 3*2^n-1, 5*2^n-1 not above it
  function automatic enc_tab_t build_enc_tab();
    enc_tab_t tab;
    int       best;
    int       cand;
    kind_e    bk;
    int       bn;
    for (int r = 0; r < 256; r++) begin
      best = 0;
      bk   = KIND_PLAIN;
      bn   = 0;
      for (int k = 0; k <= 8; k++) begin
        cand = (1 << k) - 1;
        if (cand <= r && cand > best) begin
          best = cand;
          bk   = KIND_PLAIN;
          bn   = k;
        end
        cand = (3 << k) - 1;
        if (cand <= r && cand > best) begin
          best = cand;
          bk   = KIND_TRIT;
          bn   = k;
        end
        cand = (5 << k) - 1;
        if (cand <= r && cand > best) begin
          best = cand;
          bk   = KIND_QUINT;
          bn   = k;
        end
      end
      tab[r] = {bk, NW'(bn)};
    end
    return tab;
  endfunction

  localparam enc_tab_t EncTab = build_enc_tab();

  function automatic digits_t decode_trits(logic [7:0] t);
    digits_t    r;
    logic [4:0] c;
    r = '0;
    if (t[4:2] == 3'b111) begin
      c    = {t[7:5], t[1:0]};
      r[4] = 3'd2;
      r[3] = 3'd2;
    end else begin
      c = t[4:0];
      if (t[6:5] == 2'b11) begin
        r[4] = 3'd2;
        r[3] = {2'b00, t[7]};
      end else begin
        r[4] = {2'b00, t[7]};
        r[3] = {1'b0, t[6:5]};
      end
    end
    if (c[1:0] == 2'b11) begin
      r[2] = 3'd2;
      r[1] = {2'b00, c[4]};
      r[0] = {1'b0, c[3], c[2] & ~c[3]};
    end else if (c[3:2] == 2'b11) begin
      r[2] = 3'd2;
      r[1] = 3'd2;
      r[0] = {1'b0, c[1:0]};
    end else begin
      r[2] = {2'b00, c[4]};
      r[1] = {1'b0, c[3:2]};
      r[0] = {1'b0, c[1], c[0] & ~c[1]};
    end
    return r;
  endfunction

  function automatic digits_t decode_quints(logic [6:0] q);
    digits_t    r;
    logic [4:0] c;
    logic       q0n;
    r   = '0;
    q0n = ~q[0];
    if (q[2:1] == 2'b11 && q[6:5] == 2'b00) begin
      r[0] = 3'd4;
      r[1] = 3'd4;
      r[2] = {q[0], q[4] & q0n, q[3] & q0n};
    end else begin
      if (q[2:1] == 2'b11) begin
        r[2] = 3'd4;
        c    = {q[4:3], ~q[6:5], q[0]};
      end else begin
        r[2] = {1'b0, q[6:5]};
        c    = q[4:0];
      end
      if (c[2:0] == 3'd5) begin
        r[1] = 3'd4;
        r[0] = {1'b0, c[4:3]};
      end else begin
        r[1] = {1'b0, c[4:3]};
        r[0] = c[2:0];
      end
    end
    return r;
  endfunction

  function automatic logic [IdxW-1:0] last_idx(kind_e k);
    logic [IdxW-1:0] r;
    case (k)
      KIND_TRIT:  r = LastTrit;
      KIND_QUINT: r = LastQuint;
      default:    r = LastPlain;
    endcase
    return r;
  endfunction

endpackage

>>> src/bgd_front.sv
module bgd_front (
  input  logic [7:0]      max_range_i,
  input  logic [37:0]     group_bits_i,
  input  logic            final_group_i,
  output bgd_pkg::entry_t entry_o
);
  import bgd_pkg::*;

  function automatic logic [ValW-1:0] take_bits(logic [StreamW-1:0] bits,
                                                logic [UsedW-1:0] pos,
                                                logic [NW-1:0] len);
    logic [StreamW-1:0] sh;
    logic [ValW:0]      mask;
    sh   = bits >> pos;
    mask = (9'd1 << len) - 9'd1;
    return sh[ValW-1:0] & mask[ValW-1:0];
  endfunction

  logic [EncW-1:0]  enc;
  kind_e            kind;
  logic [NW-1:0]    n;
  logic [UsedW-1:0] n6;
  vals_t            mt;
  vals_t            mq;
  logic [7:0]       tb;
  logic [6:0]       qb;
  logic [ValW-1:0]  t01, t23, t4, t56, t7, q02, q34, q56;

  assign enc  = EncTab[max_range_i];
  assign kind = kind_e'(enc[EncW-1:NW]);
  assign n    = enc[NW-1:0];
  assign n6   = UsedW'(n);

  always_comb begin
    mt     = '0;
    mt[0]  = take_bits(group_bits_i, '0, n);
    t01    = take_bits(group_bits_i, n6, 4'd2);
    mt[1]  = take_bits(group_bits_i, n6 + 6'd2, n);
    t23    = take_bits(group_bits_i, 6'd2 * n6 + 6'd2, 4'd2);
    mt[2]  = take_bits(group_bits_i, 6'd2 * n6 + 6'd4, n);
    t4     = take_bits(group_bits_i, 6'd3 * n6 + 6'd4, 4'd1);
    mt[3]  = take_bits(group_bits_i, 6'd3 * n6 + 6'd5, n);
    t56    = take_bits(group_bits_i, 6'd4 * n6 + 6'd5, 4'd2);
    mt[4]  = take_bits(group_bits_i, 6'd4 * n6 + 6'd7, n);
    t7     = take_bits(group_bits_i, 6'd5 * n6 + 6'd7, 4'd1);
    tb     = {t7[0], t56[1:0], t4[0], t23[1:0], t01[1:0]};

    mq     = '0;
    mq[0]  = mt[0];
    q02    = take_bits(group_bits_i, n6, 4'd3);
    mq[1]  = take_bits(group_bits_i, n6 + 6'd3, n);
    q34    = take_bits(group_bits_i, 6'd2 * n6 + 6'd3, 4'd2);
    mq[2]  = take_bits(group_bits_i, 6'd2 * n6 + 6'd5, n);
    q56    = take_bits(group_bits_i, 6'd3 * n6 + 6'd5, 4'd2);
    qb     = {q56[1:0], q34[1:0], q02[2:0]};

    entry_o      = '0;
    entry_o.kind = kind;
    entry_o.n    = n;
    entry_o.fin  = final_group_i;
    case (kind)
      KIND_TRIT: begin
        entry_o.m    = mt;
        entry_o.d    = decode_trits(tb);
        entry_o.used = 6'd5 * n6 + 6'd8;
      end
      KIND_QUINT: begin
        entry_o.m    = mq;
        entry_o.d    = decode_quints(qb);
        entry_o.used = 6'd3 * n6 + 6'd7;
      end
      default: begin
        entry_o.m[0] = mt[0];
        entry_o.used = n6;
      end
    endcase
  end

endmodule

>>> src/bgd_fifo.sv
module bgd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bgd_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output bgd_pkg::entry_t rdata_o,
  output logic            empty_o,
  output logic            full_o
);
  import bgd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("queue count out of range");

endmodule

>>> src/bgd_back.sv
module bgd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bgd_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output logic [7:0]      low_bits_o,
  output logic [2:0]      digit_o,
  output logic [7:0]      decoded_value_o,
  output logic [1:0]      code_kind_o,
  output logic [5:0]      group_bits_used_o,
  output logic            group_last_o,
  output logic            sequence_end_o
);
  import bgd_pkg::*;

  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 valid_q;
  logic                 last;
  logic [ValW-1:0]      sel_m;
  logic [DigitW-1:0]    sel_d;
  logic [ValW+DigitW-1:0] shifted;
  logic [ValW-1:0]      dec_val;

  logic [ValW-1:0]   low_q, val_q;
  logic [DigitW-1:0] digit_q;
  kind_e             kind_q;
  logic [UsedW-1:0]  used_q;
  logic              glast_q, send_q;

  always_comb begin
    sel_m   = head_i.m[idx_q];
    sel_d   = head_i.d[idx_q];
    shifted = (ValW+DigitW)'(sel_d) << head_i.n;
    dec_val = shifted[ValW-1:0] + sel_m;
    last    = (idx_q == last_idx(head_i.kind));
    pop_o   = !empty_i && last;
    idx_d   = idx_q;
    if (!empty_i) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= sel_m;
    digit_q <= sel_d;
    val_q   <= dec_val;
    kind_q  <= head_i.kind;
    used_q  <= head_i.used;
    glast_q <= last;
    send_q  <= last && head_i.fin;
  end

  assign result_valid_o    = valid_q;
  assign low_bits_o        = low_q;
  assign digit_o           = digit_q;
  assign decoded_value_o   = val_q;
  assign code_kind_o       = kind_q;
  assign group_bits_used_o = used_q;
  assign group_last_o      = glast_q;
  assign sequence_end_o    = send_q;

  a_send_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && sequence_end_o |-> group_last_o)
    else $error("sequence end without group end");
  a_plain_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && code_kind_o == KIND_PLAIN |-> group_last_o && digit_o == '0)
    else $error("plain group not a single value");
  a_idx_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0) else $error("value index not rewound after group");

endmodule

>>> src/bise_group_decoder.sv
// Flow: with the queue empty, a group taken on start is written into the group queue, and its
//   first result is registered at the output ports; results follow one a cycle.
// Throughput: one result per cycle from the output sequencer while a group is queued; a trit
//   group gives 5 results, a quint group 3, a plain group 1. busy is high while the group queue is full.
// Results cannot be stalled by the receiver; result_valid_o marks each one for one cycle.
// Reset clears the group queue, the value index and the result strobe; no clearing pass.
module bise_group_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  max_range_i,
  input  logic [37:0] group_bits_i,
  input  logic        final_group_i,
  output logic        result_valid_o,
  output logic [7:0]  low_bits_o,
  output logic [2:0]  digit_o,
  output logic [7:0]  decoded_value_o,
  output logic [1:0]  code_kind_o,
  output logic [5:0]  group_bits_used_o,
  output logic        group_last_o,
  output logic        sequence_end_o
);
  import bgd_pkg::*;

  entry_t new_entry, head;
  logic   push, pop, empty, full;

  assign busy = full;
  assign push = start && !full;

  bgd_front u_front (
    .max_range_i   (max_range_i),
    .group_bits_i  (group_bits_i),
    .final_group_i (final_group_i),
    .entry_o       (new_entry)
  );

  bgd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (new_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  bgd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .empty_i           (empty),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .low_bits_o        (low_bits_o),
    .digit_o           (digit_o),
    .decoded_value_o   (decoded_value_o),
    .code_kind_o       (code_kind_o),
    .group_bits_used_o (group_bits_used_o),
    .group_last_o      (group_last_o),
    .sequence_end_o    (sequence_end_o)
  );

endmodule

>>> verif/tb_bise_group_decoder.sv
`timescale 1ns / 1ps

module tb_bise_group_decoder;
  import bgd_pkg::*;

  localparam int StallLimit = 1000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 126;

  typedef struct packed {
    logic [7:0] low;
    logic [2:0] digit;
    logic [7:0] value;
    kind_e      kind;
    logic [5:0] used;
    logic       last;
    logic       seq_end;
  } result_t;

  typedef struct packed {
    logic [7:0]  range_max;
    logic [37:0] bits;
    logic        fin;
    logic        typed;
    logic [7:0]  low;
    logic [7:0]  value;
    logic [5:0]  used;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [7:0]  max_range_i   = '0;
  logic [37:0] group_bits_i  = '0;
  logic        final_group_i = 1'b0;
  logic        result_valid_o;
  logic [7:0]  low_bits_o;
  logic [2:0]  digit_o;
  logic [7:0]  decoded_value_o;
  logic [1:0]  code_kind_o;
  logic [5:0]  group_bits_used_o;
  logic        group_last_o;
  logic        sequence_end_o;

  result_t   expected_values[$];
  stim_row_t directed_rows[$];
  result_t   want;
  int        errors = 0;
  int        stall_cycles = 0;

  bise_group_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .max_range_i      (max_range_i),
    .group_bits_i     (group_bits_i),
    .final_group_i    (final_group_i),
    .result_valid_o   (result_valid_o),
    .low_bits_o       (low_bits_o),
    .digit_o          (digit_o),
    .decoded_value_o  (decoded_value_o),
    .code_kind_o      (code_kind_o),
    .group_bits_used_o(group_bits_used_o),
    .group_last_o     (group_last_o),
    .sequence_end_o   (sequence_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_pow2(int x);
    return x > 0 && (x & (x - 1)) == 0;
  endfunction

  function automatic int stream_field(logic [37:0] bits, int pos, int len);
    return int'((64'(bits) >> pos) & ((64'd1 << len) - 64'd1));
  endfunction

  // Decode one group and queue the values it yields
  function automatic void predict_group(logic [7:0] range_max, logic [37:0] bits, logic fin);
    kind_e      kind;
    int         n;
    int         c;
    int         count;
    int         pos;
    int         dpos;
    int         chunk;
    int         packed_digits;
    bit         found;
    int         m[5];
    int         d[5];
    logic [7:0] tw;
    logic [6:0] qw;
    logic [4:0] cw;
    result_t    r;
    kind  = KIND_PLAIN;
    n     = 0;
    found = 1'b0;
    for (int v = range_max; v > 0 && !found; v--) begin
      c = v + 1;
      if (is_pow2(c)) begin
        kind  = KIND_PLAIN;
        n     = $clog2(c);
        found = 1'b1;
      end else if (c % 3 == 0 && is_pow2(c / 3)) begin
        kind  = KIND_TRIT;
        n     = $clog2(c / 3);
        found = 1'b1;
      end else if (c % 5 == 0 && is_pow2(c / 5)) begin
        kind  = KIND_QUINT;
        n     = $clog2(c / 5);
        found = 1'b1;
      end
    end
    case (kind)
      KIND_TRIT:  count = 5;
      KIND_QUINT: count = 3;
      default:    count = 1;
    endcase
    pos           = 0;
    dpos          = 0;
    packed_digits = 0;
    for (int i = 0; i < 5; i++) begin
      m[i] = 0;
      d[i] = 0;
    end
    for (int i = 0; i < count; i++) begin
      case (kind)
        KIND_TRIT:  chunk = (i == 2 || i == 4) ? 1 : 2;
        KIND_QUINT: chunk = (i == 0) ? 3 : 2;
        default:    chunk = 0;
      endcase
      m[i] = stream_field(bits, pos, n);
      pos += n;
      packed_digits |= stream_field(bits, pos, chunk) << dpos;
      pos  += chunk;
      dpos += chunk;
    end
    if (kind == KIND_TRIT) begin
      tw = packed_digits[7:0];
      if (tw[4:2] == 3'b111) begin
        cw   = {tw[7:5], tw[1:0]};
        d[4] = 2;
        d[3] = 2;
      end else begin
        cw = tw[4:0];
        if (tw[6:5] == 2'b11) begin
          d[4] = 2;
          d[3] = int'(tw[7]);
        end else begin
          d[4] = int'(tw[7]);
          d[3] = int'(tw[6:5]);
        end
      end
      if (cw[1:0] == 2'b11) begin
        d[2] = 2;
        d[1] = int'(cw[4]);
        d[0] = 2 * cw[3] + (cw[2] & ~cw[3]);
      end else if (cw[3:2] == 2'b11) begin
        d[2] = 2;
        d[1] = 2;
        d[0] = int'(cw[1:0]);
      end else begin
        d[2] = int'(cw[4]);
        d[1] = int'(cw[3:2]);
        d[0] = 2 * cw[1] + (cw[0] & ~cw[1]);
      end
    end else if (kind == KIND_QUINT) begin
      qw = packed_digits[6:0];
      if (qw[2:1] == 2'b11 && qw[6:5] == 2'b00) begin
        d[0] = 4;
        d[1] = 4;
        d[2] = 4 * qw[0] + 2 * (qw[4] & ~qw[0]) + (qw[3] & ~qw[0]);
      end else begin
        if (qw[2:1] == 2'b11) begin
          d[2] = 4;
          cw   = {qw[4:3], ~qw[6:5], qw[0]};
        end else begin
          d[2] = int'(qw[6:5]);
          cw   = qw[4:0];
        end
        if (cw[2:0] == 3'd5) begin
          d[1] = 4;
          d[0] = int'(cw[4:3]);
        end else begin
          d[1] = int'(cw[4:3]);
          d[0] = int'(cw[2:0]);
        end
      end
    end
    for (int i = 0; i < count; i++) begin
      r.low     = 8'(m[i]);
      r.digit   = 3'(d[i]);
      r.value   = 8'((d[i] << n) + m[i]);
      r.kind    = kind;
      r.used    = 6'(pos);
      r.last    = (i == count - 1);
      r.seq_end = r.last & fin;
      expected_values = {expected_values, r};
    end
  endfunction

  function automatic void add_row(logic [7:0] range_max, logic [37:0] bits, logic fin,
                                  logic typed = 1'b0, logic [7:0] low = '0,
                                  logic [7:0] value = '0, logic [5:0] used = '0);
    stim_row_t row;
    row = '{range_max, bits, fin, typed, low, value, used};
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  task automatic send_group(stim_row_t row, bit may_idle);
    result_t typed_res;
    while (may_idle && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    max_range_i   <= row.range_max;
    group_bits_i  <= row.bits;
    final_group_i <= row.fin;
    do @(posedge clk_i); while (busy);
    if (row.typed) begin
      typed_res = '{row.low, 3'd0, row.value, KIND_PLAIN, row.used, 1'b1, row.fin};
      expected_values = {expected_values, typed_res};
    end else begin
      predict_group(row.range_max, row.bits, row.fin);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result: decoded_value %0d", decoded_value_o);
        errors++;
      end else begin
        want = expected_values.pop_front();
        check_field("low_bits", want.low, low_bits_o);
        check_field("digit", want.digit, digit_o);
        check_field("decoded_value", want.value, decoded_value_o);
        check_field("code_kind", want.kind, code_kind_o);
        check_field("group_bits_used", want.used, group_bits_used_o);
        check_field("group_last", want.last, group_last_o);
        check_field("sequence_end", want.seq_end, sequence_end_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    // zero range, extremes, stray high bits, rounding down
    add_row(8'd0,   '1,             1'b0, 1'b1, 8'd0,   8'd0,   6'd0);
    add_row(8'd0,   '0,             1'b1, 1'b1, 8'd0,   8'd0,   6'd0);
    add_row(8'd255, '1,             1'b1, 1'b1, 8'd255, 8'd255, 6'd8);
    add_row(8'd255, '0,             1'b0, 1'b1, 8'd0,   8'd0,   6'd8);
    add_row(8'd1,   38'h1,          1'b0, 1'b1, 8'd1,   8'd1,   6'd1);
    add_row(8'd7,   38'h3FFFFFFFFD, 1'b1, 1'b1, 8'd5,   8'd5,   6'd3);
    add_row(8'd128, 38'hAA,         1'b0, 1'b1, 8'h2A,  8'h2A,  6'd7);
    // trits
    add_row(8'd2,   '0,             1'b0);
    add_row(8'd2,   '1,             1'b1);
    add_row(8'd2,   38'h1C,         1'b0);
    add_row(8'd2,   38'h60,         1'b0);
    add_row(8'd191, '1,             1'b1);
    add_row(8'd191, '0,             1'b0);
    add_row(8'd191, 38'h2A5C3E91B7, 1'b0);
    // quints, non-canonical codes included
    add_row(8'd4,   '0,             1'b0);
    add_row(8'd4,   38'h06,         1'b1);
    add_row(8'd4,   38'h67,         1'b0);
    add_row(8'd4,   38'h05,         1'b0);
    add_row(8'd159, '1,             1'b1);
    add_row(8'd159, 38'h15A3C9,     1'b0);
    // unrepresentable ranges
    add_row(8'd6,   38'h3FF,        1'b0);
    add_row(8'd254, 38'h1F0F0F0F0F, 1'b1);
    add_row(8'd10,  38'h7FF,        1'b0);
    add_row(8'd13,  38'h12345,      1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_group(directed_rows[i], 1'b1);

    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(1)) begin
        case ($urandom_range(2))
          0:       row.range_max = 8'((1 << $urandom_range(8)) - 1);
          1:       row.range_max = 8'((3 << $urandom_range(6)) - 1);
          default: row.range_max = 8'((5 << $urandom_range(5)) - 1);
        endcase
      end else begin
        row.range_max = 8'($urandom_range(255));
      end
      row.bits  = 38'({$urandom, $urandom});
      row.fin   = 1'($urandom_range(1));
      row.typed = 1'b0;
      row.low   = '0;
      row.value = '0;
      row.used  = '0;
      // back-to-back stretch in the middle
      send_group(row, !(i >= 60 && i < 110));
    end
    start <= 1'b0;

    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bgd_pkg.sv
src/bgd_front.sv
src/bgd_fifo.sv
src/bgd_back.sv
src/bise_group_decoder.sv
verif/tb_bise_group_decoder.sv
